// File: src/uartrf_pkg.sv
// ----------------------------------------------------------------------------
// uartrf_pkg
// Types and constants shared by the uart register block and its receive queue.
// ----------------------------------------------------------------------------
package uartrf_pkg;

    // kind of item on the input stream; code 3 does nothing
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RECV  = 2'd2
    } action_t;

    // register word offsets
    localparam logic [9:0] OFF_DATA      = 10'h000;
    localparam logic [9:0] OFF_RSR       = 10'h001;
    localparam logic [9:0] OFF_FLAGS     = 10'h006;
    localparam logic [9:0] OFF_BAUD_INT  = 10'h009;
    localparam logic [9:0] OFF_BAUD_FRAC = 10'h00a;
    localparam logic [9:0] OFF_LCR       = 10'h00b;
    localparam logic [9:0] OFF_CTRL      = 10'h00c;
    localparam logic [9:0] OFF_IFLS      = 10'h00d;
    localparam logic [9:0] OFF_IMSC      = 10'h00e;
    localparam logic [9:0] OFF_RIS       = 10'h00f;
    localparam logic [9:0] OFF_MIS       = 10'h010;
    localparam logic [9:0] OFF_ICR       = 10'h011;
    localparam logic [6:0] OFF_ID_BLOCK  = 7'h7f;

    localparam logic [31:0] ID_PERIPH = 32'h0024_1011;
    localparam logic [31:0] ID_CELL   = 32'hb105_f00d;

    // bit positions
    localparam int BIT_OE  = 3;
    localparam int BIT_FEN = 4;
    localparam int BIT_LBE = 7;
    localparam int INT_RX  = 4;
    localparam int INT_TX  = 5;
    localparam int INT_RT  = 6;

    localparam logic [15:0] CTRL_MASK     = 16'hffc7;
    localparam logic [5:0]  IFLS_RESET    = 6'h12;
    localparam logic [7:0]  FLAG_TXE      = 8'h80;
    localparam logic [7:0]  FLAG_RXF      = 8'h40;
    localparam logic [7:0]  FLAG_RXE      = 8'h10;

    // commands to the receive queue
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } rxq_cmd_t;

    // one result item
    typedef struct packed {
        logic        irq;
        logic        rx_taken;
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic [31:0] rdata;
    } result_t;

endpackage

// File: src/uartrf_rxq.sv
// ----------------------------------------------------------------------------
// uartrf_rxq
// Receive queue: byte memory with head pointer and fill count. The head entry
// is read into a register on a pop.
// ----------------------------------------------------------------------------
module uartrf_rxq
    import uartrf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rxq_cmd_t                          cmd,
    input  logic [7:0]                        wbyte,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   count,
    output logic [7:0]                        rbyte
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S  = SW'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

    logic [7:0]    mem [FIFO_DEPTH];
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] waddr;
    logic [7:0]    rbyte_reg;

    // write slot is head plus count, wrapped once
    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= DEPTH_S)
        begin
            waddr = AW'(tail_sum - DEPTH_S);
        end
        else
        begin
            waddr = AW'(tail_sum);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (cmd.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[waddr] <= wbyte;
        end
        if (cmd.pop)
        begin
            rbyte_reg <= mem[head_reg];
        end
    end

    assign count = count_reg;
    assign rbyte = rbyte_reg;

endmodule

// File: src/uart_registers_with_rx_fifo.sv
// ----------------------------------------------------------------------------
// uart_registers_with_rx_fifo
// UART register block with receive FIFO, driven by a stream of bus accesses
// and received bytes.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle unless the output stalls, and every item
// gives exactly one result. All register updates happen in the cycle an item
// is transferred in; the receive FIFO lives in a single-port-write,
// single-port-read memory whose registered read output joins the result in
// the s1 stage, ahead of the output register. That output register lets one
// more item in while a result waits on the output. The FIFO
// holds FIFO_DEPTH bytes with the enable bit of the line control register set
// and one byte with it clear; toggling that bit empties it. An empty FIFO
// reads as zero in the data byte.
// ----------------------------------------------------------------------------
module uart_registers_with_rx_fifo
    import uartrf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // offset[9:0], wdata[41:10], rx_byte[49:42], zero fill
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // rdata[31:0], tx_valid[32], tx_byte[40:33],
                                        // rx_taken[41], irq[42], zero fill
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TRIG_0  = CW'(FIFO_DEPTH / 8);
    localparam logic [CW-1:0] TRIG_1  = CW'(FIFO_DEPTH / 4);
    localparam logic [CW-1:0] TRIG_2  = CW'(FIFO_DEPTH / 2);
    localparam logic [CW-1:0] TRIG_3  = CW'(FIFO_DEPTH * 3 / 4);
    localparam logic [CW-1:0] TRIG_4  = CW'(FIFO_DEPTH * 7 / 8);

    // input fields
    action_t     action;
    logic [9:0]  offset;
    logic [31:0] wdata;
    logic [7:0]  rx_byte;

    assign action  = action_t'(s_axis_tuser);
    assign offset  = s_axis_tdata[9:0];
    assign wdata   = s_axis_tdata[41:10];
    assign rx_byte = s_axis_tdata[49:42];

    // registers
    logic [10:0] raw_intr_reg,  raw_intr_next;
    logic [3:0]  rx_status_reg, rx_status_next;
    logic [15:0] ctrl_reg,      ctrl_next;
    logic [7:0]  line_ctrl_reg, line_ctrl_next;
    logic [5:0]  level_sel_reg, level_sel_next;
    logic [10:0] intr_mask_reg, intr_mask_next;
    logic [15:0] baud_int_reg,  baud_int_next;
    logic [5:0]  baud_frac_reg, baud_frac_next;
    logic        irq_reg,       irq_next;

    // pipeline
    logic        s1_valid_reg;
    logic        s1_pop_reg;
    result_t     s1_res_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    result_t     s1_full;
    logic        s1_move;
    logic        accept;

    // queue
    rxq_cmd_t      qcmd;
    logic [CW-1:0] count;
    logic [7:0]    rbyte;

    logic [CW-1:0] cap;
    logic [CW-1:0] trig;
    logic [CW-1:0] cnt_after;
    logic          loopback;
    logic          room;
    result_t       res;

    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign loopback = ctrl_reg[BIT_LBE];
    assign cap      = line_ctrl_reg[BIT_FEN] ? DEPTH_C : ONE_C;
    assign room     = count < cap;

    always_comb
    begin
        if (!line_ctrl_reg[BIT_FEN])
        begin
            trig = ONE_C;
        end
        else
        begin
            case (level_sel_reg[5:3])
                3'd0:    trig = TRIG_0;
                3'd1:    trig = TRIG_1;
                3'd2:    trig = TRIG_2;
                3'd3:    trig = TRIG_3;
                3'd4:    trig = TRIG_4;
                default: trig = DEPTH_C;
            endcase
        end
    end

    // item processing
    always_comb
    begin
        raw_intr_next  = raw_intr_reg;
        rx_status_next = rx_status_reg;
        ctrl_next      = ctrl_reg;
        line_ctrl_next = line_ctrl_reg;
        level_sel_next = level_sel_reg;
        intr_mask_next = intr_mask_reg;
        baud_int_next  = baud_int_reg;
        baud_frac_next = baud_frac_reg;
        qcmd           = '0;
        res            = '0;
        cnt_after      = count;

        case (action)
            ACT_READ:
            begin
                case (offset)
                    OFF_DATA:
                    begin
                        qcmd.pop  = (count != '0);
                        cnt_after = count - CW'(qcmd.pop);
                        if (cnt_after < trig)
                        begin
                            raw_intr_next[INT_RX] = 1'b0;
                        end
                        if (cnt_after == '0)
                        begin
                            raw_intr_next[INT_RT] = 1'b0;
                        end
                        res.rdata = {20'd0, rx_status_reg, 8'd0};
                        rx_status_next[BIT_OE] = 1'b0;
                    end
                    OFF_RSR:       res.rdata = {28'd0, rx_status_reg};
                    OFF_FLAGS:
                    begin
                        if (count == cap)
                        begin
                            res.rdata = {24'd0, FLAG_TXE | FLAG_RXF};
                        end
                        else if (count == '0)
                        begin
                            res.rdata = {24'd0, FLAG_TXE | FLAG_RXE};
                        end
                        else
                        begin
                            res.rdata = {24'd0, FLAG_TXE};
                        end
                    end
                    OFF_BAUD_INT:  res.rdata = {16'd0, baud_int_reg};
                    OFF_BAUD_FRAC: res.rdata = {26'd0, baud_frac_reg};
                    OFF_LCR:       res.rdata = {24'd0, line_ctrl_reg};
                    OFF_CTRL:      res.rdata = {16'd0, ctrl_reg};
                    OFF_IFLS:      res.rdata = {26'd0, level_sel_reg};
                    OFF_IMSC:      res.rdata = {21'd0, intr_mask_reg};
                    OFF_RIS:       res.rdata = {21'd0, raw_intr_reg};
                    OFF_MIS:       res.rdata = {21'd0, raw_intr_reg & intr_mask_reg};
                    default:
                    begin
                        // identification bytes at the top of the map
                        if (offset[9:3] == OFF_ID_BLOCK)
                        begin
                            if (offset[2])
                            begin
                                res.rdata = {24'd0, ID_CELL[{offset[1:0], 3'd0} +: 8]};
                            end
                            else
                            begin
                                res.rdata = {24'd0, ID_PERIPH[{offset[1:0], 3'd0} +: 8]};
                            end
                        end
                    end
                endcase
            end
            ACT_WRITE:
            begin
                case (offset)
                    OFF_DATA:
                    begin
                        if (loopback)
                        begin
                            qcmd.push = room;
                            if (!room)
                            begin
                                rx_status_next[BIT_OE] = 1'b1;
                            end
                        end
                        else
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = wdata[7:0];
                        end
                        raw_intr_next[INT_TX] = 1'b1;
                    end
                    OFF_RSR:       rx_status_next = '0;
                    OFF_BAUD_INT:  baud_int_next  = wdata[15:0];
                    OFF_BAUD_FRAC: baud_frac_next = wdata[5:0];
                    OFF_LCR:
                    begin
                        qcmd.clear     = line_ctrl_reg[BIT_FEN] ^ wdata[BIT_FEN];
                        line_ctrl_next = wdata[7:0];
                    end
                    OFF_CTRL:      ctrl_next      = wdata[15:0] & CTRL_MASK;
                    OFF_IFLS:      level_sel_next = wdata[5:0];
                    OFF_IMSC:      intr_mask_next = wdata[10:0];
                    OFF_ICR:       raw_intr_next  = raw_intr_reg & ~wdata[10:0];
                    default:       ;
                endcase
            end
            ACT_RECV:
            begin
                if (loopback)
                begin
                    // byte dropped, queue untouched
                    res.rx_taken = 1'b1;
                    if (count != '0)
                    begin
                        raw_intr_next[INT_RT] = 1'b1;
                    end
                end
                else
                begin
                    qcmd.push    = room;
                    res.rx_taken = room;
                    cnt_after    = count + CW'(room);
                    if (count < trig && cnt_after >= trig)
                    begin
                        raw_intr_next[INT_RX] = 1'b1;
                    end
                    if (cnt_after != '0)
                    begin
                        raw_intr_next[INT_RT] = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // line follows masked raw bits, except for a dropped loopback byte and no-op
        if (action == ACT_READ || action == ACT_WRITE || (action == ACT_RECV && !loopback))
        begin
            irq_next = |(raw_intr_next & intr_mask_next);
        end
        else
        begin
            irq_next = irq_reg;
        end
        res.irq = irq_next;

        if (!accept)
        begin
            qcmd = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_intr_reg  <= '0;
            rx_status_reg <= '0;
            ctrl_reg      <= '0;
            line_ctrl_reg <= '0;
            level_sel_reg <= IFLS_RESET;
            intr_mask_reg <= '0;
            baud_int_reg  <= '0;
            baud_frac_reg <= '0;
            irq_reg       <= 1'b0;
        end
        else if (accept)
        begin
            raw_intr_reg  <= raw_intr_next;
            rx_status_reg <= rx_status_next;
            ctrl_reg      <= ctrl_next;
            line_ctrl_reg <= line_ctrl_next;
            level_sel_reg <= level_sel_next;
            intr_mask_reg <= intr_mask_next;
            baud_int_reg  <= baud_int_next;
            baud_frac_reg <= baud_frac_next;
            irq_reg       <= irq_next;
        end
    end

    uartrf_rxq #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rxq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (qcmd),
        .wbyte (wdata[7:0] & {8{action == ACT_WRITE}} | rx_byte & {8{action == ACT_RECV}}),
        .count (count),
        .rbyte (rbyte)
    );

    // popped byte from the memory joins the result here
    always_comb
    begin
        s1_full = s1_res_reg;
        if (s1_pop_reg)
        begin
            s1_full.rdata[7:0] = rbyte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
            s1_pop_reg <= qcmd.pop;
        end
        if (s1_move)
        begin
            out_res_reg <= s1_full;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg};

endmodule
